// ----- src/at_cls_pkg.sv -----
// ----------------------------------------------------------------------------
// at_cls_pkg
// Shared types, constants and per-character update functions for the
// AT command line classifier.
// ----------------------------------------------------------------------------
package at_cls_pkg;

    // Default line buffer size; counts saturate at min(size - 2, 511)
    localparam int LINE_BUFFER_DEF = 512;

    localparam int NKW = 9;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Line kinds
    localparam logic [3:0] KIND_ROK   = 4'd0;
    localparam logic [3:0] KIND_OK    = 4'd1;
    localparam logic [3:0] KIND_ERR   = 4'd2;
    localparam logic [3:0] KIND_UNK   = 4'd3;
    localparam logic [3:0] KIND_JAAC  = 4'd4;
    localparam logic [3:0] KIND_JPRO  = 4'd5;
    localparam logic [3:0] KIND_JRES  = 4'd6;
    localparam logic [3:0] KIND_JSDA  = 4'd7;
    localparam logic [3:0] KIND_UNSUP = 4'd10;

    // Warning codes
    localparam logic [2:0] WARN_NONE     = 3'd0;
    localparam logic [2:0] WARN_FLAG     = 3'd1;
    localparam logic [2:0] WARN_JRES     = 3'd2;
    localparam logic [2:0] WARN_NO_COMMA = 3'd3;
    localparam logic [2:0] WARN_LEN      = 3'd4;

    // Keyword candidate bits
    localparam int KW_ROK = 6;
    localparam int KW_OK  = 7;
    localparam int KW_ERR = 8;

    // Length parser stages
    localparam logic [2:0] PS_IDLE      = 3'd0;
    localparam logic [2:0] PS_PLUS      = 3'd1;
    localparam logic [2:0] PS_MINUS     = 3'd2;
    localparam logic [2:0] PS_DIGIT     = 3'd3;
    localparam logic [2:0] PS_NEG_DIGIT = 3'd4;
    localparam logic [2:0] PS_STOP      = 3'd5;
    localparam logic [2:0] PS_NEG_STOP  = 3'd6;

    // Keyword text, lengths, and whether the keyword must be the whole line
    localparam logic [7:0] KW_TEXT [NKW][7] = '{
        '{8'h41, 8'h54, 8'h2B, 8'h4A, 8'h41, 8'h41, 8'h43},  // AT+JAAC
        '{8'h41, 8'h54, 8'h2B, 8'h4A, 8'h50, 8'h52, 8'h4F},  // AT+JPRO
        '{8'h41, 8'h54, 8'h2B, 8'h4A, 8'h52, 8'h45, 8'h53},  // AT+JRES
        '{8'h41, 8'h54, 8'h2B, 8'h4A, 8'h53, 8'h44, 8'h41},  // AT+JSDA
        '{8'h41, 8'h54, 8'h2B, 8'h4A, 8'h53, 8'h45, 8'h43},  // AT+JSEC
        '{8'h41, 8'h54, 8'h2B, 8'h4A, 8'h53, 8'h4C, 8'h4E},  // AT+JSLN
        '{8'h52, 8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00},  // ROK
        '{8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // OK
        '{8'h45, 8'h52, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00}   // ERR
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd3, 4'd2, 4'd3
    };
    localparam logic [NKW-1:0] KW_EXACT = 9'b0_1100_0000;

    // Per-stream line state
    typedef struct packed {
        logic [8:0]     line_count;
        logic           pending_cr;
        logic [NKW-1:0] keyword_match;
        logic [2:0]     param_stage;
        logic [7:0]     param_first;
        logic [8:0]     param_count;
        logic           comma_seen;
        logic [15:0]    length_accum;
        logic [8:0]     after_comma_count;
        logic [31:0]    recent_chars;
    } t_line_state;

    // One classified line
    typedef struct packed {
        logic        line_direction;
        logic [3:0]  line_kind;
        logic [2:0]  warning_code;
        logic        flag_value;
        logic [15:0] declared_length;
        logic [8:0]  data_length;
        logic [31:0] tail_chars;
    } t_line_result;

    localparam t_line_state LINE_CLEAR = '{
        line_count:        '0,
        pending_cr:        1'b0,
        keyword_match:     '1,
        param_stage:       PS_IDLE,
        param_first:       '0,
        param_count:       '0,
        comma_seen:        1'b0,
        length_accum:      '0,
        after_comma_count: '0,
        recent_chars:      '0
    };

    // Saturating increment
    function automatic logic [8:0] sat_inc(input logic [8:0] v, input logic [8:0] cap);
        return (v >= cap) ? cap : v + 9'd1;
    endfunction

    // Advance the declared-length parser by one parameter character
    function automatic t_line_state parse_len(input t_line_state st, input logic [7:0] b);
        t_line_state ns;
        logic        dig;
        logic        ws;
        logic [19:0] v;
        ns  = st;
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        ws  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        v   = ({4'b0, st.length_accum} * 20'd10) + {12'b0, b - CH_ZERO};
        if (dig && (st.param_stage <= PS_NEG_DIGIT)) begin
            ns.length_accum = (v > 20'd65535) ? 16'hFFFF : v[15:0];
            ns.param_stage  = ((st.param_stage == PS_MINUS) ||
                               (st.param_stage == PS_NEG_DIGIT)) ? PS_NEG_DIGIT : PS_DIGIT;
        end else if (st.param_stage == PS_IDLE) begin
            if (b == CH_PLUS) begin
                ns.param_stage = PS_PLUS;
            end else if (b == CH_MINUS) begin
                ns.param_stage = PS_MINUS;
            end else if (!ws) begin
                ns.param_stage = PS_STOP;
            end
        end else if ((st.param_stage == PS_MINUS) || (st.param_stage == PS_NEG_DIGIT)) begin
            ns.param_stage = PS_NEG_STOP;
        end else if (st.param_stage != PS_NEG_STOP) begin
            ns.param_stage = PS_STOP;
        end
        return ns;
    endfunction

    // Take one content character into the line state
    function automatic t_line_state line_push(input t_line_state st, input logic [7:0] b,
                                              input logic [8:0] cap);
        t_line_state ns;
        logic [8:0]  pos;
        ns  = st;
        pos = st.line_count;
        // Drop keyword candidates that no longer fit
        for (int k = 0; k < NKW; k++) begin
            if (pos < {5'b0, KW_LEN[k]}) begin
                if (b != KW_TEXT[k][pos[2:0]]) begin
                    ns.keyword_match[k] = 1'b0;
                end
            end else if (KW_EXACT[k]) begin
                ns.keyword_match[k] = 1'b0;
            end
        end
        // Parameter bytes follow the seven-character command, one '=' skipped
        if ((pos >= 9'd7) && !((pos == 9'd7) && (b == CH_EQ))) begin
            if (st.param_count == 9'd0) begin
                ns.param_first = b;
            end
            ns.param_count = sat_inc(st.param_count, cap);
            ns = parse_len(ns, b);
            if (st.comma_seen) begin
                ns.after_comma_count = sat_inc(st.after_comma_count, cap);
            end else if (b == CH_COMMA) begin
                ns.comma_seen = 1'b1;
            end
        end
        ns.recent_chars = {st.recent_chars[23:0], b};
        ns.line_count   = sat_inc(pos, cap);
        return ns;
    endfunction

endpackage

// ----- src/at_cls_step.sv -----
// ----------------------------------------------------------------------------
// at_cls_step
// Combinational update of one stream's line state for one character, and
// the classification of the line when CR LF ends it.
// ----------------------------------------------------------------------------
module at_cls_step
    import at_cls_pkg::*;
(
    input  t_line_state  i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_dir,
    input  logic [8:0]   i_cap,
    output t_line_state  o_state,
    output logic         o_done,
    output t_line_result o_result
);

    t_line_state after_cr;
    logic        is_neg;

    // Fold a held CR back into the line when no LF follows, then take the byte
    always_comb begin
        after_cr = i_state;
        if (i_state.pending_cr) begin
            after_cr            = line_push(i_state, CH_CR, i_cap);
            after_cr.pending_cr = 1'b0;
        end
        o_done  = i_state.pending_cr && (i_byte == CH_LF);
        o_state = after_cr;
        if (o_done) begin
            o_state = LINE_CLEAR;
        end else if (i_byte == CH_CR) begin
            o_state.pending_cr = 1'b1;
        end else begin
            o_state = line_push(after_cr, i_byte, i_cap);
        end
    end

    assign is_neg = (i_state.param_stage == PS_MINUS) ||
                    (i_state.param_stage == PS_NEG_DIGIT) ||
                    (i_state.param_stage == PS_NEG_STOP);

    // Classify the finished line
    always_comb begin
        o_result                = '0;
        o_result.line_direction = i_dir;
        o_result.tail_chars     = i_state.recent_chars;
        o_result.warning_code   = WARN_NONE;
        if (!i_dir) begin
            if (i_state.keyword_match[KW_ROK] && (i_state.line_count == 9'd3)) begin
                o_result.line_kind = KIND_ROK;
            end else if (i_state.keyword_match[KW_OK] && (i_state.line_count == 9'd2)) begin
                o_result.line_kind = KIND_OK;
            end else if (i_state.keyword_match[KW_ERR] && (i_state.line_count >= 9'd3)) begin
                o_result.line_kind = KIND_ERR;
            end else begin
                o_result.line_kind = KIND_UNK;
            end
        end else begin
            o_result.line_kind = KIND_UNSUP;
            if (i_state.line_count >= 9'd7) begin
                for (int k = 5; k >= 0; k--) begin
                    if (i_state.keyword_match[k]) begin
                        o_result.line_kind = KIND_JAAC + 4'(k);
                    end
                end
            end
            if ((o_result.line_kind == KIND_JAAC) || (o_result.line_kind == KIND_JPRO)) begin
                if ((i_state.param_count == 9'd1) &&
                    ((i_state.param_first == CH_ZERO) || (i_state.param_first == CH_ONE))) begin
                    o_result.flag_value = (i_state.param_first == CH_ONE);
                end else begin
                    o_result.warning_code = WARN_FLAG;
                end
            end else if (o_result.line_kind == KIND_JRES) begin
                if (i_state.line_count != 9'd7) begin
                    o_result.warning_code = WARN_JRES;
                end
            end else if (o_result.line_kind == KIND_JSDA) begin
                o_result.declared_length = i_state.length_accum;
                if (!i_state.comma_seen) begin
                    o_result.warning_code = WARN_NO_COMMA;
                end else begin
                    o_result.data_length = i_state.after_comma_count;
                    if (is_neg ? ((i_state.length_accum != 16'd0) ||
                                  (i_state.after_comma_count != 9'd0))
                               : (i_state.length_accum !=
                                  {7'b0, i_state.after_comma_count})) begin
                        o_result.warning_code = WARN_LEN;
                    end
                end
            end
        end
    end

endmodule

// ----- src/at_command_line_classifier.sv -----
// ----------------------------------------------------------------------------
// at_command_line_classifier
// Splits two tagged UART streams into CR LF lines and classifies each line.
// ----------------------------------------------------------------------------
// A line result is registered from the LF item held in the input register.
// Throughput: one item per cycle unless a line-ending item waits; the line
// state of each stream is updated combinationally between the input register and the result register.
// An item that ends a line waits while an earlier result is still untaken.
// Reset clears both streams' line state and empties both registers.
module at_command_line_classifier
    import at_cls_pkg::*;
#(
    parameter int LINE_BUFFER = LINE_BUFFER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_direction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_line_direction,
    output logic [3:0]  o_line_kind,
    output logic [2:0]  o_warning_code,
    output logic        o_flag_value,
    output logic [15:0] o_declared_length,
    output logic [8:0]  o_data_length,
    output logic [31:0] o_tail_chars
);

    localparam int         CAP_INT = ((LINE_BUFFER - 2) > 511) ? 511 : (LINE_BUFFER - 2);
    localparam logic [8:0] CNT_CAP = 9'(CAP_INT);

    logic         r_in_valid;
    logic [7:0]   r_byte;
    logic         r_dir;
    t_line_state  r_state [2];
    t_line_state  n_state;
    logic         step_done;
    t_line_result step_result;
    logic         advance;
    logic         r_out_valid;
    t_line_result r_result;

    at_cls_step u_step (
        .i_state  (r_state[r_dir]),
        .i_byte   (r_byte),
        .i_dir    (r_dir),
        .i_cap    (CNT_CAP),
        .o_state  (n_state),
        .o_done   (step_done),
        .o_result (step_result)
    );

    // Advance the held item unless it ends a line and the result slot is full
    assign advance    = r_in_valid && (!step_done || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_data_byte;
            r_dir  <= i_direction;
        end
    end

    // Update the line state of the item's stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state[0] <= LINE_CLEAR;
            r_state[1] <= LINE_CLEAR;
        end else if (advance) begin
            r_state[r_dir] <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && step_done) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_line_direction  = r_result.line_direction;
    assign o_line_kind       = r_result.line_kind;
    assign o_warning_code    = r_result.warning_code;
    assign o_flag_value      = r_result.flag_value;
    assign o_declared_length = r_result.declared_length;
    assign o_data_length     = r_result.data_length;
    assign o_tail_chars      = r_result.tail_chars;

endmodule
